// ----- hdl/ptd_pkg.sv -----
package ptd_pkg;

	// Default table depth and the cap on due reports per tick
	localparam int MAX_TASKS_DEF = 16;
	localparam int MAX_RESULTS   = 16;

	// Field widths
	localparam int ID_W   = 8;
	localparam int TIME_W = 32;
	localparam int ACT_W  = 2;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_TICK     = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ARRANGE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DISMISS  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RESTART  = 2'd3;

	// Result kinds and status codes
	localparam logic KIND_DUE    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_FAIL     = 1'b1;

	// One table entry
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] last_run;
	} slot_t;

	// Per-cycle commands broadcast to every cell
	typedef struct packed {
		logic rotate;
		logic restart;
		logic arrange;
		logic append;
		logic dismiss;
	} cell_ctl_t;

endpackage

// ----- hdl/ptd_cell.sv -----
module ptd_cell (
	input  logic                        clk,
	input  ptd_pkg::cell_ctl_t          ctl,
	input  logic                        used,
	input  logic                        tail,
	input  logic [ptd_pkg::ID_W-1:0]    key_id,
	input  logic [ptd_pkg::TIME_W-1:0]  key_period,
	input  logic [ptd_pkg::TIME_W-1:0]  now,
	input  ptd_pkg::slot_t              nbr,
	input  logic                        found_i,
	output logic                        found_o,
	output ptd_pkg::slot_t              slot
);
	import ptd_pkg::*;

	slot_t slot_q;
	logic  match;

	// Compare own id and pass the found flag down the row
	assign match   = used && (slot_q.id == key_id);
	assign found_o = found_i || match;
	assign slot    = slot_q;

	// Take the neighbor on rotate or on a dismiss at or above this cell
	always_ff @(posedge clk) begin
		if (ctl.rotate || (ctl.dismiss && found_o)) begin
			slot_q <= nbr;
		end else if (ctl.restart) begin
			slot_q.last_run <= now;
		end else if (ctl.arrange && match && !found_i) begin
			slot_q.period <= key_period;
		end else if (ctl.append && tail) begin
			slot_q.id       <= key_id;
			slot_q.period   <= key_period;
			slot_q.last_run <= '0;
		end
	end

endmodule

// ----- hdl/periodic_task_dispatcher.sv -----
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     action, task_id, period, now
// out      output     out_valid / out_stall   kind, due_id, status, last
//
// Arrange, dismiss and restart each answer with a status report, which is in the
// output register on the edge after the request.
// Tick rotates the row of cells once around; the rotation pauses while a
// report waits in the stalled output register.
// Reset clears the task count and all control state; cell contents are
// only read below the task count.
// A new request is taken only when no tick scan runs and the output
// register is free or being emptied.
module periodic_task_dispatcher #(
	parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ptd_pkg::ACT_W-1:0]   action,
	input  logic [ptd_pkg::ID_W-1:0]    task_id,
	input  logic [ptd_pkg::TIME_W-1:0]  period,
	input  logic [ptd_pkg::TIME_W-1:0]  now,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [ptd_pkg::ID_W-1:0]    due_id,
	output logic                        status,
	output logic                        last
);
	import ptd_pkg::*;

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int RW = $clog2(MAX_RESULTS + 1);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     step_q;
	logic [RW-1:0]     n_q;
	logic              busy_q;
	logic [TIME_W-1:0] now_q;
	logic              pend_valid_q;
	logic [ID_W-1:0]   pend_id_q;
	logic              out_valid_q;
	logic              out_kind_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_status_q;
	logic              out_last_q;

	cell_ctl_t         ctl;
	slot_t             slots [MAX_TASKS];
	slot_t             wrap;
	logic [MAX_TASKS:0] found;

	logic              accept;
	logic              out_free;
	logic              scanning;
	logic              full;
	logic              found_any;
	logic [TIME_W-1:0] elapsed;
	logic              due;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = busy_q || !out_free;
	assign accept    = in_valid && !in_stall;
	assign scanning  = busy_q && (step_q != CW'(MAX_TASKS));
	assign full      = (count_q == CW'(MAX_TASKS));
	assign found_any = found[MAX_TASKS];

	// Test the head cell while the row turns
	assign elapsed = now_q - slots[0].last_run;
	assign due     = (step_q < count_q) && (elapsed >= slots[0].period)
		&& (n_q < RW'(MAX_RESULTS));

	// Stamp the head with the tick time, if it is due, as it wraps to the tail
	always_comb begin
		wrap = slots[0];
		if (due) begin
			wrap.last_run = now_q;
		end
	end

	// Commands for the row
	always_comb begin
		ctl.rotate  = scanning && out_free;
		ctl.restart = accept && (action == ACT_RESTART);
		ctl.arrange = accept && (action == ACT_ARRANGE);
		ctl.append  = accept && (action == ACT_ARRANGE) && !found_any && !full;
		ctl.dismiss = accept && (action == ACT_DISMISS);
	end

	assign found[0] = 1'b0;

	// Row of cells
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		slot_t nbr;
		if (i == MAX_TASKS - 1) begin : g_tail
			assign nbr = wrap;
		end else begin : g_mid
			assign nbr = slots[i+1];
		end
		ptd_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.used       (CW'(i) < count_q),
			.tail       (CW'(i) == count_q),
			.key_id     (task_id),
			.key_period (period),
			.now        (now),
			.nbr        (nbr),
			.found_i    (found[i]),
			.found_o    (found[i+1]),
			.slot       (slots[i])
		);
	end

	// Task count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.append) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.dismiss && found_any) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Tick scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			step_q       <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
		end else if (accept && (action == ACT_TICK)) begin
			busy_q       <= 1'b1;
			step_q       <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
		end else if (ctl.rotate) begin
			step_q <= step_q + CW'(1);
			if (due) begin
				n_q          <= n_q + RW'(1);
				pend_valid_q <= 1'b1;
			end
		end else if (busy_q && !scanning && out_free) begin
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
		end
	end

	// Scan payload
	always_ff @(posedge clk) begin
		if (accept && (action == ACT_TICK)) begin
			now_q <= now;
		end
		if (ctl.rotate && due) begin
			pend_id_q <= slots[0].id;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (action != ACT_TICK)) begin
			out_valid_q <= 1'b1;
		end else if (ctl.rotate && due && pend_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (busy_q && !scanning && out_free && pend_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (accept && (action != ACT_TICK)) begin
			out_kind_q   <= KIND_STATUS;
			out_id_q     <= '0;
			out_last_q   <= 1'b1;
			case (action)
				ACT_ARRANGE: out_status_q <= (found_any || !full) ? ST_OK : ST_FAIL;
				ACT_DISMISS: out_status_q <= found_any ? ST_OK : ST_FAIL;
				default:     out_status_q <= ST_OK;
			endcase
		end else if (ctl.rotate && due && pend_valid_q) begin
			out_kind_q   <= KIND_DUE;
			out_id_q     <= pend_id_q;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
		end else if (busy_q && !scanning && out_free && pend_valid_q) begin
			out_kind_q   <= KIND_DUE;
			out_id_q     <= pend_id_q;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign due_id    = out_id_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

	// Table never overfills
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TASKS))
		else $error("task count above table depth");

	// Report cap holds
	a_n_max: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RW'(MAX_RESULTS))
		else $error("due report count above cap");

	// Held due report only exists inside a scan
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> busy_q)
		else $error("pending report outside a tick scan");

	// Commands answer with a status report on the next edge
	a_cmd_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action != ACT_TICK)) |=> (out_valid_q && out_kind_q == KIND_STATUS
			&& out_last_q))
		else $error("command without status report");

	// Scan with nothing held ends once the row has turned
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !scanning && !pend_valid_q) |=> !busy_q)
		else $error("tick scan did not finish");

endmodule

// ----- tb/ptd_checker.sv -----
// Scoreboard for the periodic task dispatcher: mirrors the task table,
// predicts the reports of each accepted request and compares every
// accepted report against the oldest prediction.
module ptd_checker #(
	parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [ptd_pkg::ACT_W-1:0]   action,
	input  logic [ptd_pkg::ID_W-1:0]    task_id,
	input  logic [ptd_pkg::TIME_W-1:0]  period,
	input  logic [ptd_pkg::TIME_W-1:0]  now,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        kind,
	input  logic [ptd_pkg::ID_W-1:0]    due_id,
	input  logic                        status,
	input  logic                        last,
	output int                          fail_count,
	output int                          pending,
	output int                          request_count,
	output int                          report_count,
	output int                          due_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import ptd_pkg::*;

	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] due_id;
		logic            status;
		logic            last;
	} report_t;

	// Mirror of the task table
	logic [ID_W-1:0]   tbl_id     [MAX_TASKS];
	logic [TIME_W-1:0] tbl_period [MAX_TASKS];
	logic [TIME_W-1:0] tbl_stamp  [MAX_TASKS];
	int                tbl_count;

	report_t awaited_reports[$];
	int      fails;
	int      n_requests;
	int      n_reports;
	int      n_due;

	// Work out the reports of one request and update the table mirror
	function automatic void dispatch_request(input logic [ACT_W-1:0] act,
		input logic [ID_W-1:0] id, input logic [TIME_W-1:0] per,
		input logic [TIME_W-1:0] stamp);
		report_t           rep;
		report_t           held;
		bit                have_held;
		logic [TIME_W-1:0] elapsed;
		int                hit;
		int                n;
		logic              st;
		hit = -1;
		n = 0;
		st = ST_OK;
		have_held = 1'b0;
		for (int i = 0; i < tbl_count; i++) begin
			if (hit < 0 && tbl_id[i] == id)
				hit = i;
		end
		case (act)
			ACT_TICK: begin
				// report due tasks in table order, mark the final one
				for (int i = 0; i < tbl_count && n < MAX_RESULTS; i++) begin
					elapsed = stamp - tbl_stamp[i];
					if (elapsed >= tbl_period[i]) begin
						tbl_stamp[i] = stamp;
						if (have_held)
							awaited_reports.push_back(held);
						held = '{KIND_DUE, tbl_id[i], ST_OK, 1'b0};
						have_held = 1'b1;
						n++;
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					awaited_reports.push_back(held);
				end
			end
			ACT_ARRANGE: begin
				if (hit >= 0) begin
					tbl_period[hit] = per;
				end else if (tbl_count >= MAX_TASKS) begin
					st = ST_FAIL;
				end else begin
					tbl_id[tbl_count] = id;
					tbl_period[tbl_count] = per;
					tbl_stamp[tbl_count] = '0;
					tbl_count++;
				end
			end
			ACT_DISMISS: begin
				// close the gap, keep the order of the rest
				if (hit < 0) begin
					st = ST_FAIL;
				end else begin
					for (int i = hit; i + 1 < tbl_count; i++) begin
						tbl_id[i] = tbl_id[i + 1];
						tbl_period[i] = tbl_period[i + 1];
						tbl_stamp[i] = tbl_stamp[i + 1];
					end
					tbl_count--;
				end
			end
			default: begin
				for (int i = 0; i < tbl_count; i++)
					tbl_stamp[i] = stamp;
			end
		endcase
		if (act != ACT_TICK) begin
			rep = '{KIND_STATUS, '0, st, 1'b1};
			awaited_reports.push_back(rep);
		end
	endfunction

	function automatic bit field_ok(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Compare one accepted report with the oldest prediction
	function automatic void check_report();
		report_t want;
		bit      ok;
		if (awaited_reports.size() == 0) begin
			$display("%0t: unexpected report, expected none, %s",
				$time, "actual below");
			$display("%0t: kind=%0d due_id=%0h status=%0d last=%0d",
				$time, kind, due_id, status, last);
			fails++;
			return;
		end
		want = awaited_reports.pop_front();
		ok = field_ok("kind", 32'(want.kind), 32'(kind));
		ok = field_ok("due_id", 32'(want.due_id), 32'(due_id)) && ok;
		ok = field_ok("status", 32'(want.status), 32'(status)) && ok;
		ok = field_ok("last", 32'(want.last), 32'(last)) && ok;
		if (!ok)
			fails++;
		n_reports++;
		if (want.kind == KIND_DUE)
			n_due++;
	endfunction

	// Watch both channels: reports first, then the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_count = 0;
			awaited_reports.delete();
			fails = 0;
			n_requests = 0;
			n_reports = 0;
			n_due = 0;
		end else begin
			if (out_valid && !out_stall)
				check_report();
			if (in_valid && !in_stall) begin
				dispatch_request(action, task_id, period, now);
				n_requests++;
			end
		end
		fail_count <= fails;
		pending <= awaited_reports.size();
		request_count <= n_requests;
		report_count <= n_reports;
		due_count <= n_due;
	end

endmodule

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ptd_pkg::*;

	localparam int RAND_PER_PHASE = 120;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 4 * (MAX_TASKS_DEF + 1);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [ACT_W-1:0]  action = ACT_TICK;
	logic [ID_W-1:0]   task_id = '0;
	logic [TIME_W-1:0] period = '0;
	logic [TIME_W-1:0] now = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              kind;
	logic [ID_W-1:0]   due_id;
	logic              status;
	logic              last;

	int          fail_count;
	int          pending;
	int          request_count;
	int          report_count;
	int          due_count;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_req = 1'b0;
	logic [TIME_W-1:0] clock_ms = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	periodic_task_dispatcher #(.MAX_TASKS(MAX_TASKS_DEF)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .task_id(task_id), .period(period), .now(now),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .due_id(due_id), .status(status), .last(last)
	);

	ptd_checker #(.MAX_TASKS(MAX_TASKS_DEF)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .task_id(task_id), .period(period), .now(now),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .due_id(due_id), .status(status), .last(last),
		.fail_count(fail_count), .pending(pending),
		.request_count(request_count), .report_count(report_count),
		.due_count(due_count)
	);

	// Offer one request, hold it until taken, then maybe leave a gap
	task automatic offer_request(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] stamp);
		in_valid <= 1'b1;
		action <= act;
		task_id <= id;
		period <= per;
		now <= stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			action <= ACT_W'($urandom);
			task_id <= ID_W'($urandom);
			@(posedge clk);
		end
	endtask

	// Mostly a small pool so that updates and dismissals hit
	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(99) < 80)
			return ID_W'($urandom_range(23, 0));
		return ID_W'($urandom);
	endfunction

	function automatic logic [TIME_W-1:0] pick_period();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return '0;
		if (roll < 70)
			return $urandom_range(12, 1);
		if (roll < 85)
			return $urandom_range(200, 13);
		if (roll < 95)
			return $urandom;
		return 32'hFFFF_FFFF;
	endfunction

	// Advance time, with occasional jumps and wraps
	task automatic advance_clock();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4)
			clock_ms = $urandom;
		else if (roll < 8)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(10, 0);
		else
			clock_ms = clock_ms + $urandom_range(6, 0);
	endtask

	task automatic random_request();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 45) begin
			advance_clock();
			offer_request(ACT_TICK, ID_W'($urandom), $urandom, clock_ms);
		end else if (roll < 72) begin
			offer_request(ACT_ARRANGE, pick_id(), pick_period(), $urandom);
		end else if (roll < 92) begin
			offer_request(ACT_DISMISS, pick_id(), $urandom, $urandom);
		end else begin
			advance_clock();
			offer_request(ACT_RESTART, ID_W'($urandom), $urandom, clock_ms);
		end
	endtask

	// Output side: random stall, plus a long hold on request
	initial begin
		bit hold_seen;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, update, wrap, dismissals
		offer_request(ACT_TICK, 8'h00, '0, 32'h0000_0000);
		offer_request(ACT_RESTART, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0010);
		offer_request(ACT_DISMISS, 8'hFF, '0, '0);
		offer_request(ACT_ARRANGE, 8'h00, 32'h0000_0000, '0);
		offer_request(ACT_ARRANGE, 8'hFF, 32'hFFFF_FFFF, '0);
		offer_request(ACT_ARRANGE, 8'h5A, 32'd10, '0);
		offer_request(ACT_ARRANGE, 8'h00, 32'd3, '0);
		offer_request(ACT_ARRANGE, 8'h11, 32'd0, '0);
		offer_request(ACT_TICK, '0, '0, 32'd2);
		offer_request(ACT_TICK, '0, '0, 32'd5);
		offer_request(ACT_TICK, '0, '0, 32'hFFFF_FFFF);
		offer_request(ACT_RESTART, '0, '0, 32'hFFFF_FFF0);
		offer_request(ACT_TICK, '0, '0, 32'hFFFF_FFF2);
		offer_request(ACT_TICK, '0, '0, 32'h0000_0005);
		offer_request(ACT_DISMISS, 8'h00, '0, '0);
		offer_request(ACT_DISMISS, 8'h00, '0, '0);
		offer_request(ACT_DISMISS, 8'h5A, '0, '0);
		offer_request(ACT_TICK, '0, '0, 32'h0000_0006);

		// Fill the table with always-due tasks, overflow it, then hold output
		for (int i = 0; i < 20; i++)
			offer_request(ACT_ARRANGE, ID_W'(8'h80 + i), '0, '0);
		hold_req <= ~hold_req;
		offer_request(ACT_TICK, '0, '0, 32'd100);
		offer_request(ACT_TICK, '0, '0, 32'd101);
		offer_request(ACT_ARRANGE, 8'h81, 32'd2, '0);
		offer_request(ACT_TICK, '0, '0, 32'd102);
		offer_request(ACT_ARRANGE, 8'hFF, 32'd0, '0);
		offer_request(ACT_TICK, '0, '0, 32'd103);
		for (int i = 0; i < 20; i++)
			offer_request(ACT_DISMISS, ID_W'(8'h80 + i), '0, '0);
		offer_request(ACT_DISMISS, 8'hFF, '0, '0);
		offer_request(ACT_DISMISS, 8'h11, '0, '0);

		// Random traffic under three idle mixes
		send_idle_pct = 22;
		recv_idle_pct = 52;
		for (int k = 0; k < RAND_PER_PHASE; k++)
			random_request();
		send_idle_pct = 52;
		recv_idle_pct = 22;
		for (int k = 0; k < RAND_PER_PHASE; k++)
			random_request();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int k = 0; k < RAND_PER_PHASE; k++)
			random_request();
		in_valid <= 1'b0;

		// Drain outstanding reports, then let a last scan finish
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Run covered %0d requests and %0d checked reports, %0d of them due reports.",
			request_count, report_count, due_count);
		$display("Idle mixes 22/52, 52/22 and none, one long output hold; %0d mismatches.",
			fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/ptd_pkg.sv
hdl/ptd_cell.sv
hdl/periodic_task_dispatcher.sv
tb/ptd_checker.sv
tb/tb.sv
